// File: src/rap_pkg.sv
// Shared types, register codes and reset values for the rotate-and-pack pixel core.
package rap_pkg;

   localparam int CoordFieldBits  = 12;
   localparam int PhysDimBits     = 13;
   localparam int LineBytesBits   = 14;
   localparam int OffsetFieldBits = 20;
   localparam int LengthFieldBits = 16;
   localparam int CsrDataBits     = 20;
   localparam int CsrIndexBits    = 3;
   localparam int ByteOffsetBits  = 26;
   localparam int PixelBits       = 32;
   localparam int ByteCountBits   = 3;
   localparam int ChannelCount    = 4;
   localparam int ChanOffsetBits  = 5;
   localparam int ChanLengthBits  = 4;
   localparam int ChanValueBits   = 8;
   localparam int SignedCoordBits = PhysDimBits + 2;
   localparam int RowBytesBits    = PhysDimBits + LineBytesBits;
   localparam int ColBytesBits    = PhysDimBits + 2;
   localparam int AlphaChannel    = 3;

   localparam logic [1:0] RotDeg0   = 2'd0;
   localparam logic [1:0] RotDeg90  = 2'd1;
   localparam logic [1:0] RotDeg180 = 2'd2;
   localparam logic [1:0] RotDeg270 = 2'd3;

   localparam logic [1:0] Depth16   = 2'd0;
   localparam logic [1:0] Depth24   = 2'd1;
   localparam logic [1:0] Depth32   = 2'd2;
   localparam logic [1:0] DepthNone = 2'd3;

   localparam logic [ByteCountBits-1:0] Bytes16 = 3'd2;
   localparam logic [ByteCountBits-1:0] Bytes24 = 3'd3;
   localparam logic [ByteCountBits-1:0] Bytes32 = 3'd4;

   localparam logic [PhysDimBits-1:0]     PhysWidthReset  = 13'd480;
   localparam logic [PhysDimBits-1:0]     PhysHeightReset = 13'd800;
   localparam logic [LineBytesBits-1:0]   LineBytesReset  = 14'd1920;
   localparam logic [OffsetFieldBits-1:0] OffsetsReset    = 20'hC4100;
   localparam logic [LengthFieldBits-1:0] LengthsReset    = 16'h8888;

   typedef enum logic [CsrIndexBits-1:0] {
      CsrRotation   = 3'd0,
      CsrPhysWidth  = 3'd1,
      CsrPhysHeight = 3'd2,
      CsrLineBytes  = 3'd3,
      CsrPixelDepth = 3'd4,
      CsrOffsets    = 3'd5,
      CsrLengths    = 3'd6
   } rap_csr_index_type;

   typedef struct packed {
      logic [1:0]                 rotation;
      logic [PhysDimBits-1:0]     phys_width;
      logic [PhysDimBits-1:0]     phys_height;
      logic [LineBytesBits-1:0]   line_bytes;
      logic [1:0]                 pixel_depth;
      logic [OffsetFieldBits-1:0] channel_offsets;
      logic [LengthFieldBits-1:0] channel_lengths;
   } rap_cfg_type;

   typedef struct packed {
      logic [CoordFieldBits-1:0] logical_x;
      logic [CoordFieldBits-1:0] logical_y;
      logic [PixelBits-1:0]      pixel_argb;
   } rap_req_type;

   typedef struct packed {
      logic                      write_enable;
      logic [ByteOffsetBits-1:0] byte_offset;
      logic [PixelBits-1:0]      packed_pixel;
      logic [ByteCountBits-1:0]  byte_count;
   } rap_rsp_type;

endpackage

// File: src/rotate_and_pack_pixel_core.sv
// Top level: input register, pixel calculation and result register with stall handling.
// An item is held in the input register and then in the result register. Throughput is
// one item per cycle while rsp_stall is low. The path between the two registers is the
// rotation subtract, the bounds compare and the 13 x 14 row multiply with the column add.
// Reset clears both valid flags and loads the default configuration.
module rotate_and_pack_pixel_core #(
   parameter int COORD_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [rap_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [rap_pkg::CsrDataBits-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rap_pkg::rap_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rap_pkg::rap_rsp_type             rsp_data
);
   import rap_pkg::*;

   rap_cfg_type cfg;
   rap_req_type req_ff;
   rap_req_type req_in;
   logic        req_valid_ff;
   logic        req_valid_in;
   rap_rsp_type rsp_ff;
   rap_rsp_type rsp_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rap_rsp_type calc_rsp;
   logic        rsp_load;
   logic        req_load;

   rap_config_regs u_config_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   rap_pixel_calc #(
      .COORD_BITS (COORD_BITS)
   ) u_pixel_calc (
      .cfg (cfg),
      .req (req_ff),
      .rsp (calc_rsp)
   );

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign req_load  = !req_valid_ff || rsp_load;
   assign req_stall = !req_load;

   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in       = calc_rsp;
         rsp_valid_in = req_valid_ff;
      end
      if (req_load) begin
         req_in       = req_data;
         req_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/rap_config_regs.sv
// Configuration register file with write port and reset defaults.
module rap_config_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [rap_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [rap_pkg::CsrDataBits-1:0]     csr_wdata,
   output rap_pkg::rap_cfg_type                cfg
);
   import rap_pkg::*;

   rap_cfg_type cfg_ff;
   rap_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CsrRotation:   cfg_in.rotation        = csr_wdata[1:0];
            CsrPhysWidth:  cfg_in.phys_width      = csr_wdata[PhysDimBits-1:0];
            CsrPhysHeight: cfg_in.phys_height     = csr_wdata[PhysDimBits-1:0];
            CsrLineBytes:  cfg_in.line_bytes      = csr_wdata[LineBytesBits-1:0];
            CsrPixelDepth: cfg_in.pixel_depth     = csr_wdata[1:0];
            CsrOffsets:    cfg_in.channel_offsets = csr_wdata[OffsetFieldBits-1:0];
            CsrLengths:    cfg_in.channel_lengths = csr_wdata[LengthFieldBits-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation        <= RotDeg0;
         cfg_ff.phys_width      <= PhysWidthReset;
         cfg_ff.phys_height     <= PhysHeightReset;
         cfg_ff.line_bytes      <= LineBytesReset;
         cfg_ff.pixel_depth     <= Depth32;
         cfg_ff.channel_offsets <= OffsetsReset;
         cfg_ff.channel_lengths <= LengthsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/rap_pixel_calc.sv
// Rotation, bounds check, byte offset and channel packing for one pixel.
module rap_pixel_calc #(
   parameter int COORD_BITS = 12
) (
   input  rap_pkg::rap_cfg_type cfg,
   input  rap_pkg::rap_req_type req,
   output rap_pkg::rap_rsp_type rsp
);
   import rap_pkg::*;

   localparam int UsedBits = (COORD_BITS < CoordFieldBits) ? COORD_BITS : CoordFieldBits;
   localparam logic signed [SignedCoordBits-1:0] One  = SignedCoordBits'(1);
   localparam logic signed [SignedCoordBits-1:0] Zero = '0;

   function automatic logic [PixelBits-1:0] pack_channel(
      input logic [ChanValueBits-1:0]  value,
      input logic [ChanLengthBits-1:0] len,
      input logic [ChanOffsetBits-1:0] off
   );
      logic [ChanLengthBits-1:0] sat;
      logic [PixelBits-1:0]      cut;
      sat = (len > ChanLengthBits'(ChanValueBits)) ? ChanLengthBits'(ChanValueBits) : len;
      cut = PixelBits'(value) >> (ChanLengthBits'(ChanValueBits) - sat);
      return cut << off;
   endfunction

   logic signed [SignedCoordBits-1:0] lx;
   logic signed [SignedCoordBits-1:0] ly;
   logic signed [SignedCoordBits-1:0] w;
   logic signed [SignedCoordBits-1:0] h;
   logic signed [SignedCoordBits-1:0] px;
   logic signed [SignedCoordBits-1:0] py;
   logic                              in_bounds;
   logic [PhysDimBits-1:0]            col;
   logic [PhysDimBits-1:0]            row;
   logic [RowBytesBits-1:0]           row_bytes;
   logic [ColBytesBits-1:0]           col_bytes;
   logic [ByteCountBits-1:0]          bytes;
   logic [PixelBits-1:0]              packed_all;
   logic [PixelBits-1:0]              packed_cut;

   assign lx = SignedCoordBits'(req.logical_x[UsedBits-1:0]);
   assign ly = SignedCoordBits'(req.logical_y[UsedBits-1:0]);
   assign w  = SignedCoordBits'(cfg.phys_width);
   assign h  = SignedCoordBits'(cfg.phys_height);

   always_comb begin
      case (cfg.rotation)
         RotDeg90: begin
            px = w - One - ly;
            py = lx;
         end
         RotDeg180: begin
            px = w - One - lx;
            py = h - One - ly;
         end
         RotDeg270: begin
            px = ly;
            py = h - One - lx;
         end
         default: begin
            px = lx;
            py = ly;
         end
      endcase
   end

   assign in_bounds = (px >= Zero) && (px < w) && (py >= Zero) && (py < h)
                      && (cfg.pixel_depth != DepthNone);

   assign col = px[PhysDimBits-1:0];
   assign row = py[PhysDimBits-1:0];
   assign row_bytes = RowBytesBits'(row) * RowBytesBits'(cfg.line_bytes);

   always_comb begin
      case (cfg.pixel_depth)
         Depth16: begin
            bytes     = Bytes16;
            col_bytes = ColBytesBits'({col, 1'b0});
         end
         Depth24: begin
            bytes     = Bytes24;
            col_bytes = ColBytesBits'({col, 1'b0}) + ColBytesBits'(col);
         end
         default: begin
            bytes     = Bytes32;
            col_bytes = ColBytesBits'({col, 2'b00});
         end
      endcase
   end

   always_comb begin
      packed_all = '0;
      for (int i = 0; i < ChannelCount; i++) begin
         if (i != AlphaChannel || cfg.pixel_depth == Depth32) begin
            packed_all = packed_all
               | pack_channel(req.pixel_argb[ChanValueBits*i +: ChanValueBits],
                              cfg.channel_lengths[ChanLengthBits*i +: ChanLengthBits],
                              cfg.channel_offsets[ChanOffsetBits*i +: ChanOffsetBits]);
         end
      end
   end

   always_comb begin
      packed_cut = packed_all;
      case (cfg.pixel_depth)
         Depth16: packed_cut[PixelBits-1:16] = '0;
         Depth24: packed_cut[PixelBits-1:24] = '0;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp = '0;
      if (in_bounds) begin
         rsp.write_enable = 1'b1;
         rsp.byte_offset  = ByteOffsetBits'(row_bytes + RowBytesBits'(col_bytes));
         rsp.packed_pixel = packed_cut;
         rsp.byte_count   = bytes;
      end
   end

endmodule
